@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the indexed array table engine.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/iate_pkg.sv @@
// Package for the indexed array table engine: field widths, request and status
// codes, controller states, datapath commands and the status struct.
// No dependencies.
`timescale 1ns / 1ps

package iate_pkg;

	localparam int unsigned DEPTH_DEF = 1024;
	localparam int unsigned KIND_W    = 3;
	localparam int unsigned POS_W     = 11;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned STAT_W    = 2;

	// Request kinds; codes six and seven change nothing but still give an OK result.
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT  = 3'd0,
		KIND_DELETE  = 3'd1,
		KIND_LSEARCH = 3'd2,
		KIND_BSEARCH = 3'd3,
		KIND_SORT    = 3'd4,
		KIND_READ    = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SHIFT_UP,
		S_INS_PUT,
		S_SHIFT_DN,
		S_DEL_END,
		S_SCAN,
		S_BIN_PROBE,
		S_BIN_CMP,
		S_SORT_STEP,
		S_SORT_TAIL,
		S_RD_TAKE,
		S_FINISH
	} state_t;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_LATCH,
		CMD_FAIL_FULL,
		CMD_FAIL_POS,
		CMD_INS_START,
		CMD_DEL_START,
		CMD_LIN_START,
		CMD_BIN_START,
		CMD_SORT_START,
		CMD_RD_ISSUE,
		CMD_SHIFT_UP,
		CMD_SHIFT_DN,
		CMD_INS_PUT,
		CMD_DEL_END,
		CMD_SCAN,
		CMD_BIN_PROBE,
		CMD_BIN_CMP,
		CMD_SORT_STEP,
		CMD_SORT_TAIL,
		CMD_RD_TAKE,
		CMD_FINISH
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  ins_bad;
		logic  pos_bad;
		logic  up_go;
		logic  fwd_go;
		logic  pipe_busy;
		logic  hit;
		logic  bin_empty;
		logic  sort_small;
		logic  swapped;
		logic  out_free;
	} dp_stat_t;

endpackage

@@ rtl/iate_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iate_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/iate_ctrl.sv @@
// Controller state machine of the indexed array table engine.
// Depends on iate_pkg for states, commands and the datapath status struct.
`timescale 1ns / 1ps

module iate_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  iate_pkg::dp_stat_t stat,
	output iate_pkg::cmd_t     cmd
);

	iate_pkg::state_t state_q;
	iate_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iate_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			iate_pkg::S_IDLE: begin
				if (in_valid) state_d = iate_pkg::S_DISPATCH;
			end
			iate_pkg::S_DISPATCH: begin
				case (stat.kind)
					iate_pkg::KIND_INSERT: begin
						if (stat.full || stat.ins_bad) state_d = iate_pkg::S_FINISH;
						else state_d = iate_pkg::S_SHIFT_UP;
					end
					iate_pkg::KIND_DELETE: begin
						if (stat.pos_bad) state_d = iate_pkg::S_FINISH;
						else state_d = iate_pkg::S_SHIFT_DN;
					end
					iate_pkg::KIND_LSEARCH: state_d = iate_pkg::S_SCAN;
					iate_pkg::KIND_BSEARCH: state_d = iate_pkg::S_BIN_PROBE;
					iate_pkg::KIND_SORT: begin
						if (stat.sort_small) state_d = iate_pkg::S_FINISH;
						else state_d = iate_pkg::S_SORT_STEP;
					end
					iate_pkg::KIND_READ: begin
						if (stat.pos_bad) state_d = iate_pkg::S_FINISH;
						else state_d = iate_pkg::S_RD_TAKE;
					end
					default: state_d = iate_pkg::S_FINISH;
				endcase
			end
			iate_pkg::S_SHIFT_UP: begin
				if (!stat.up_go && !stat.pipe_busy) state_d = iate_pkg::S_INS_PUT;
			end
			iate_pkg::S_INS_PUT: state_d = iate_pkg::S_FINISH;
			iate_pkg::S_SHIFT_DN: begin
				if (!stat.fwd_go && !stat.pipe_busy) state_d = iate_pkg::S_DEL_END;
			end
			iate_pkg::S_DEL_END: state_d = iate_pkg::S_FINISH;
			iate_pkg::S_SCAN: begin
				if (stat.hit || (!stat.fwd_go && !stat.pipe_busy)) begin
					state_d = iate_pkg::S_FINISH;
				end
			end
			iate_pkg::S_BIN_PROBE: begin
				if (stat.hit || stat.bin_empty) state_d = iate_pkg::S_FINISH;
				else state_d = iate_pkg::S_BIN_CMP;
			end
			iate_pkg::S_BIN_CMP: state_d = iate_pkg::S_BIN_PROBE;
			iate_pkg::S_SORT_STEP: begin
				if (!stat.fwd_go && !stat.pipe_busy) state_d = iate_pkg::S_SORT_TAIL;
			end
			iate_pkg::S_SORT_TAIL: begin
				if (stat.swapped) state_d = iate_pkg::S_SORT_STEP;
				else state_d = iate_pkg::S_FINISH;
			end
			iate_pkg::S_RD_TAKE: state_d = iate_pkg::S_FINISH;
			iate_pkg::S_FINISH: begin
				if (stat.out_free) state_d = iate_pkg::S_IDLE;
			end
			default: state_d = iate_pkg::S_IDLE;
		endcase
	end

	// Outputs: handshake and datapath command.
	always_comb begin
		in_ready = 1'b0;
		cmd      = iate_pkg::CMD_NOP;
		case (state_q)
			iate_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd = iate_pkg::CMD_LATCH;
			end
			iate_pkg::S_DISPATCH: begin
				case (stat.kind)
					iate_pkg::KIND_INSERT: begin
						if (stat.full) cmd = iate_pkg::CMD_FAIL_FULL;
						else if (stat.ins_bad) cmd = iate_pkg::CMD_FAIL_POS;
						else cmd = iate_pkg::CMD_INS_START;
					end
					iate_pkg::KIND_DELETE: begin
						if (stat.pos_bad) cmd = iate_pkg::CMD_FAIL_POS;
						else cmd = iate_pkg::CMD_DEL_START;
					end
					iate_pkg::KIND_LSEARCH: cmd = iate_pkg::CMD_LIN_START;
					iate_pkg::KIND_BSEARCH: cmd = iate_pkg::CMD_BIN_START;
					iate_pkg::KIND_SORT: begin
						if (!stat.sort_small) cmd = iate_pkg::CMD_SORT_START;
					end
					iate_pkg::KIND_READ: begin
						if (stat.pos_bad) cmd = iate_pkg::CMD_FAIL_POS;
						else cmd = iate_pkg::CMD_RD_ISSUE;
					end
					default: cmd = iate_pkg::CMD_NOP;
				endcase
			end
			iate_pkg::S_SHIFT_UP:  cmd = iate_pkg::CMD_SHIFT_UP;
			iate_pkg::S_INS_PUT:   cmd = iate_pkg::CMD_INS_PUT;
			iate_pkg::S_SHIFT_DN:  cmd = iate_pkg::CMD_SHIFT_DN;
			iate_pkg::S_DEL_END:   cmd = iate_pkg::CMD_DEL_END;
			iate_pkg::S_SCAN:      cmd = iate_pkg::CMD_SCAN;
			iate_pkg::S_BIN_PROBE: begin
				if (!stat.hit && !stat.bin_empty) cmd = iate_pkg::CMD_BIN_PROBE;
			end
			iate_pkg::S_BIN_CMP:   cmd = iate_pkg::CMD_BIN_CMP;
			iate_pkg::S_SORT_STEP: cmd = iate_pkg::CMD_SORT_STEP;
			iate_pkg::S_SORT_TAIL: cmd = iate_pkg::CMD_SORT_TAIL;
			iate_pkg::S_RD_TAKE:   cmd = iate_pkg::CMD_RD_TAKE;
			iate_pkg::S_FINISH: begin
				if (stat.out_free) cmd = iate_pkg::CMD_FINISH;
			end
			default: cmd = iate_pkg::CMD_NOP;
		endcase
	end

endmodule

@@ rtl/iate_dp.sv @@
// Datapath of the indexed array table engine: request registers, entry count,
// walk pointer, entry RAM, compare logic and the result register.
// Depends on iate_pkg, iate_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iate_dp #(
	parameter int unsigned DEPTH = iate_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  iate_pkg::cmd_t              cmd,
	output iate_pkg::dp_stat_t          stat,
	input  logic [iate_pkg::KIND_W-1:0] in_kind,
	input  logic [iate_pkg::POS_W-1:0]  in_position,
	input  logic [iate_pkg::VAL_W-1:0]  in_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [iate_pkg::STAT_W-1:0] out_status,
	output logic [iate_pkg::POS_W-1:0]  out_found,
	output logic [iate_pkg::VAL_W-1:0]  out_read_value,
	output logic [iate_pkg::POS_W-1:0]  out_length
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = ((CW > iate_pkg::POS_W) ? CW : iate_pkg::POS_W) + 1;

	// Request and walk registers.
	iate_pkg::kind_t              kind_q;
	logic [iate_pkg::POS_W-1:0]   pos_q;
	logic [iate_pkg::VAL_W-1:0]   val_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                ptr_q;
	logic [XW-1:0]                lo_q;
	logic [XW-1:0]                hi_q;
	logic [XW-1:0]                mid_q;
	logic [iate_pkg::VAL_W-1:0]   held_q;
	logic                         hit_q;
	logic                         swapped_q;
	logic                         vld_s1;
	logic [AW-1:0]                addr_s1;

	// Result staging and output register.
	iate_pkg::status_t            res_status_q;
	logic [iate_pkg::POS_W-1:0]   res_found_q;
	logic [iate_pkg::VAL_W-1:0]   res_rd_q;
	logic                         out_valid_q;
	logic [iate_pkg::STAT_W-1:0]  out_status_q;
	logic [iate_pkg::POS_W-1:0]   out_found_q;
	logic [iate_pkg::VAL_W-1:0]   out_rd_q;
	logic [iate_pkg::POS_W-1:0]   out_length_q;

	// RAM ports.
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [iate_pkg::VAL_W-1:0]   ram_wdata;
	logic [AW-1:0]                ram_raddr;
	logic [iate_pkg::VAL_W-1:0]   ram_rdata;

	// Derived values.
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] ptr_x;
	logic [XW-1:0] mid;
	logic          up_go;
	logic          fwd_go;
	logic          match_now;
	logic          scan_issue;
	logic          held_gt;
	logic          rd_gt_key;

	assign pos_x     = XW'(pos_q);
	assign cnt_x     = XW'(count_q);
	assign ptr_x     = XW'(ptr_q);
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign up_go     = (ptr_x >= pos_x);
	assign fwd_go    = (ptr_x < cnt_x);
	assign match_now = vld_s1 && !hit_q && (ram_rdata == val_q);
	assign scan_issue = fwd_go && !hit_q && !match_now;
	assign held_gt   = ($signed(held_q) > $signed(ram_rdata));
	assign rd_gt_key = ($signed(ram_rdata) > $signed(val_q));

	// Status to the controller.
	always_comb begin
		stat.kind       = kind_q;
		stat.full       = (count_q == CW'(DEPTH));
		stat.ins_bad    = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
		stat.pos_bad    = (pos_x == '0) || (pos_x > cnt_x);
		stat.up_go      = up_go;
		stat.fwd_go     = fwd_go;
		stat.pipe_busy  = vld_s1;
		stat.hit        = hit_q;
		stat.bin_empty  = (lo_q > hi_q);
		stat.sort_small = (cnt_x <= XW'(1));
		stat.swapped    = swapped_q;
		stat.out_free   = !out_valid_q || out_ready;
	end

	// Read address of the RAM.
	always_comb begin
		case (cmd)
			iate_pkg::CMD_SHIFT_UP:  ram_raddr = AW'(ptr_x - XW'(1));
			iate_pkg::CMD_BIN_PROBE: ram_raddr = AW'(mid - XW'(1));
			iate_pkg::CMD_RD_ISSUE:  ram_raddr = AW'(pos_x - XW'(1));
			default:                 ram_raddr = AW'(ptr_q);
		endcase
	end

	// Write port of the RAM.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = ram_rdata;
		case (cmd)
			iate_pkg::CMD_SHIFT_UP: begin
				ram_we    = vld_s1;
				ram_waddr = addr_s1 + AW'(1);
			end
			iate_pkg::CMD_SHIFT_DN: begin
				ram_we    = vld_s1;
				ram_waddr = addr_s1 - AW'(1);
			end
			iate_pkg::CMD_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(pos_x - XW'(1));
				ram_wdata = val_q;
			end
			iate_pkg::CMD_SORT_STEP: begin
				// The smaller of the held word and the new one settles one slot lower.
				ram_we    = vld_s1 && (addr_s1 != '0);
				ram_waddr = addr_s1 - AW'(1);
				ram_wdata = held_gt ? ram_rdata : held_q;
			end
			iate_pkg::CMD_SORT_TAIL: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(cnt_x - XW'(1));
				ram_wdata = held_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	iate_ram #(
		.WIDTH(iate_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control registers: count, read pipeline flag, match and swap flags,
	// output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			swapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			case (cmd)
				iate_pkg::CMD_LATCH:      hit_q <= 1'b0;
				iate_pkg::CMD_SHIFT_UP:   vld_s1 <= up_go;
				iate_pkg::CMD_SHIFT_DN:   vld_s1 <= fwd_go;
				iate_pkg::CMD_INS_PUT:    count_q <= count_q + CW'(1);
				iate_pkg::CMD_DEL_END:    count_q <= count_q - CW'(1);
				iate_pkg::CMD_SCAN: begin
					vld_s1 <= scan_issue;
					if (match_now) hit_q <= 1'b1;
				end
				iate_pkg::CMD_BIN_CMP: begin
					if (ram_rdata == val_q) hit_q <= 1'b1;
				end
				iate_pkg::CMD_SORT_START: swapped_q <= 1'b0;
				iate_pkg::CMD_SORT_STEP: begin
					vld_s1 <= fwd_go;
					if (vld_s1 && (addr_s1 != '0) && held_gt) swapped_q <= 1'b1;
				end
				iate_pkg::CMD_SORT_TAIL:  swapped_q <= 1'b0;
				default: begin
				end
			endcase
			// Output register: load on finish, clear on a taken transfer.
			if (cmd == iate_pkg::CMD_FINISH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd)
			iate_pkg::CMD_LATCH: begin
				kind_q       <= iate_pkg::kind_t'(in_kind);
				pos_q        <= in_position;
				val_q        <= in_value;
				res_status_q <= iate_pkg::ST_OK;
				res_found_q  <= '0;
				res_rd_q     <= '0;
			end
			iate_pkg::CMD_FAIL_FULL: res_status_q <= iate_pkg::ST_FULL;
			iate_pkg::CMD_FAIL_POS:  res_status_q <= iate_pkg::ST_BADPOS;
			iate_pkg::CMD_INS_START: ptr_q <= count_q;
			iate_pkg::CMD_DEL_START: ptr_q <= CW'(pos_x);
			iate_pkg::CMD_LIN_START: begin
				ptr_q        <= '0;
				res_status_q <= iate_pkg::ST_NOTFOUND;
			end
			iate_pkg::CMD_BIN_START: begin
				lo_q         <= XW'(1);
				hi_q         <= cnt_x;
				res_status_q <= iate_pkg::ST_NOTFOUND;
			end
			iate_pkg::CMD_SORT_START: ptr_q <= '0;
			iate_pkg::CMD_SHIFT_UP: begin
				addr_s1 <= ram_raddr;
				if (up_go) ptr_q <= ptr_q - CW'(1);
			end
			iate_pkg::CMD_SHIFT_DN: begin
				addr_s1 <= ram_raddr;
				if (fwd_go) ptr_q <= ptr_q + CW'(1);
			end
			iate_pkg::CMD_SCAN: begin
				addr_s1 <= ram_raddr;
				if (scan_issue) ptr_q <= ptr_q + CW'(1);
				if (match_now) begin
					res_status_q <= iate_pkg::ST_OK;
					res_found_q  <= iate_pkg::POS_W'(XW'(addr_s1) + XW'(1));
				end
			end
			iate_pkg::CMD_BIN_PROBE: mid_q <= mid;
			iate_pkg::CMD_BIN_CMP: begin
				// Bisection step: hit, or keep the half that can hold the key.
				if (ram_rdata == val_q) begin
					res_status_q <= iate_pkg::ST_OK;
					res_found_q  <= iate_pkg::POS_W'(mid_q);
				end else if (rd_gt_key) begin
					hi_q <= mid_q - XW'(1);
				end else begin
					lo_q <= mid_q + XW'(1);
				end
			end
			iate_pkg::CMD_SORT_STEP: begin
				addr_s1 <= ram_raddr;
				if (fwd_go) ptr_q <= ptr_q + CW'(1);
				if (vld_s1) begin
					if (addr_s1 == '0) held_q <= ram_rdata;
					else if (!held_gt) held_q <= ram_rdata;
				end
			end
			iate_pkg::CMD_SORT_TAIL: ptr_q <= '0;
			iate_pkg::CMD_RD_TAKE: begin
				res_found_q <= pos_q;
				res_rd_q    <= ram_rdata;
			end
			iate_pkg::CMD_FINISH: begin
				out_status_q <= res_status_q;
				out_found_q  <= res_found_q;
				out_rd_q     <= res_rd_q;
				out_length_q <= iate_pkg::POS_W'(count_q);
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign out_status     = out_status_q;
	assign out_found      = out_found_q;
	assign out_read_value = out_rd_q;
	assign out_length     = out_length_q;

	// Checks on count, write range, output overrun and bisection range.
	`ASSERT_NOW(a_count_max, 1'b1, XW'(count_q) <= XW'(DEPTH), "entry count beyond depth")
	`ASSERT_NOW(a_write_range, ram_we, XW'(ram_waddr) <= cnt_x, "write past the table end")
	`ASSERT_NOW(a_no_overrun, cmd == iate_pkg::CMD_FINISH, !out_valid_q || out_ready,
		"result register overwritten")
	`ASSERT_NOW(a_bin_mid, cmd == iate_pkg::CMD_BIN_PROBE,
		(mid >= XW'(1)) && (mid <= cnt_x), "bisection probe out of range")

endmodule

@@ rtl/indexed_array_table_engine_core.sv @@
// Indexed array table engine: an ordered table of signed 32-bit words, 1-based,
// with insert, delete, linear search, binary search, sort and read requests.
// Depends on iate_pkg, iate_ctrl and iate_dp.
`timescale 1ns / 1ps

// One request is worked at a time, and each gives one result transfer; a new
// request is taken while the previous result still waits in the output
// register. All entries live in a single RAM with one write and one registered
// read port, which sets the cost of every request: insert and delete move one
// entry per cycle; linear search reads one entry per cycle; binary search
// passes through a probe state and a compare state for each probe; sort runs
// exchange passes and repeats until a pass swaps nothing. Entries never
// written read as anything, but only entries 1..length are ever read, so no
// clearing is needed after reset.
module indexed_array_table_engine_core #(
	parameter int unsigned DEPTH = iate_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // position[10:0], value[42:11], zero[47:43]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // found_position[10:0], read_value[42:11],
	                              // length[53:43], zero[55:54]
	output logic [1:0]  m_tuser   // status[1:0]
);

	iate_pkg::cmd_t     cmd;
	iate_pkg::dp_stat_t stat;

	logic [iate_pkg::POS_W-1:0] out_found;
	logic [iate_pkg::VAL_W-1:0] out_read_value;
	logic [iate_pkg::POS_W-1:0] out_length;

	// Controller.
	iate_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Datapath.
	iate_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_kind       (s_tuser),
		.in_position   (s_tdata[10:0]),
		.in_value      (s_tdata[42:11]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_status    (m_tuser),
		.out_found     (out_found),
		.out_read_value(out_read_value),
		.out_length    (out_length)
	);

	// Pack the result transfer.
	assign m_tdata = {2'b00, out_length, out_read_value, out_found};

endmodule
